>>> sv/ias_pkg.sv
`timescale 1ns / 1ps

package ias_pkg;

   // Width of one stored word
   localparam int WORD_W = 32;
   // Width of the slot index field
   localparam int SLOT_W = 8;
   // Width of the reported fill count
   localparam int FILL_W = 9;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_GET    = 2'd1,
      OP_SET    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_MISSING = 2'd3
   } status_type;

endpackage

>>> sv/ias_ram.sv
`timescale 1ns / 1ps

module ias_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/indexed_array_store.sv
// indexed_array_store: a store of signed 32-bit words with a fill count.
// Request channel: req_op, req_slot_index, req_word_value are taken at a
// rising edge where start is high and busy is low. Operations are append,
// get by slot, set at slot (zero-filling any gap past the end) and remove
// by value (first match, later words move down one place).
// Response channel: rsp_strobe is high for exactly one cycle with
// rsp_status, rsp_read_word and rsp_fill_count; the receiver cannot stall,
// so the word must be taken in that cycle.
// From the accepting edge to the strobe cycle:
//   append, set inside the array, a rejected append, get or set, and
//   remove on an empty store: the result is registered from idle
//   get: ST_GET_RD passes the registered RAM read on to the result
//   set past the end: ST_FILL zeroes the gap, then writes the word
//   remove: ST_SCAN compares words up to the first match, ST_SHIFT
//   moves the later words down, and then the result is registered.
// All of it runs through one single-port-write RAM and one compare on the
// word read back each cycle; busy stays high until the strobe cycle, and a
// new request may be taken in the strobe cycle itself.
// Reset clears the fill count and the sequencer; RAM contents are left
// as they are and are never read below the fill count before written.
`timescale 1ns / 1ps

module indexed_array_store #(
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  ias_pkg::op_type                  req_op,
   input  logic [ias_pkg::SLOT_W-1:0]       req_slot_index,
   input  logic signed [ias_pkg::WORD_W-1:0] req_word_value,
   output logic                             rsp_strobe,
   output ias_pkg::status_type              rsp_status,
   output logic signed [ias_pkg::WORD_W-1:0] rsp_read_word,
   output logic [ias_pkg::FILL_W-1:0]       rsp_fill_count
);

   import ias_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET_RD,
      ST_FILL,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]   rsp_word_ff, rsp_word_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic [AW-1:0]       rd_addr;
   logic [WORD_W-1:0]   rd_data;

   logic [XW-1:0]       req_idx_x;
   logic [XW-1:0]       idx_x;
   logic [XW-1:0]       count_x;
   logic [XW-1:0]       ptr_x;
   logic [CW:0]         ptr_p1;
   logic [CW:0]         ptr_p2;
   logic [CW:0]         count_w;

   ias_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_idx_x = XW'(req_slot_index);
   assign idx_x     = XW'(idx_ff);
   assign count_x   = XW'(count_ff);
   assign ptr_x     = XW'(ptr_ff);
   assign ptr_p1    = (CW + 1)'(ptr_ff) + (CW + 1)'(1);
   assign ptr_p2    = (CW + 1)'(ptr_ff) + (CW + 1)'(2);
   assign count_w   = (CW + 1)'(count_ff);

   // Sequence one request through the RAM
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_word_in   = rsp_word_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[AW-1:0];
      wr_data       = word_ff;
      rd_addr       = ptr_p1[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in      = req_slot_index;
               word_in     = req_word_value;
               rsp_word_in = '0;
               case (req_op)
                  OP_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == DEPTH_C) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = count_ff[AW-1:0];
                        wr_data       = req_word_value;
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = STAT_OK;
                     end
                  end
                  OP_GET: begin
                     // count never exceeds DEPTH, so this also guards capacity
                     if (req_idx_x >= count_x) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_RANGE;
                     end else begin
                        rd_addr  = req_idx_x[AW-1:0];
                        state_in = ST_GET_RD;
                     end
                  end
                  OP_SET: begin
                     if (req_idx_x >= DEPTH_X) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_FULL;
                     end else if (req_idx_x < count_x) begin
                        wr_en         = 1'b1;
                        wr_addr       = req_idx_x[AW-1:0];
                        wr_data       = req_word_value;
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_OK;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = ST_FILL;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_MISSING;
                     end else begin
                        rd_addr  = '0;
                        ptr_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GET_RD: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_word_in   = rd_data;
            state_in      = ST_IDLE;
         end
         ST_FILL: begin
            // Zero the gap, then drop the word at its slot
            wr_en = 1'b1;
            if (ptr_x == idx_x) begin
               wr_data       = word_ff;
               count_in      = CW'(idx_x + XW'(1));
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_OK;
               state_in      = ST_IDLE;
            end else begin
               wr_data = '0;
               ptr_in  = ptr_ff + CW'(1);
            end
         end
         ST_SCAN: begin
            // Compare the entry at ptr; the next one is already being read
            if (rd_data == word_ff) begin
               if (ptr_p1 == count_w) begin
                  count_in      = count_ff - CW'(1);
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_SHIFT;
               end
            end else if (ptr_p1 == count_w) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_MISSING;
               state_in      = ST_IDLE;
            end else begin
               ptr_in = ptr_p1[CW-1:0];
            end
         end
         ST_SHIFT: begin
            // Move entry ptr+1 down to ptr, prefetch ptr+2
            wr_en   = 1'b1;
            wr_data = rd_data;
            rd_addr = ptr_p2[AW-1:0];
            ptr_in  = ptr_p1[CW-1:0];
            if (ptr_p2 == count_w) begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= STAT_OK;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_status_ff <= rsp_status_in;
      end
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_word  = rsp_word_ff;
   assign rsp_fill_count = FILL_W'(count_ff);

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("fill count above capacity");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("response issued while sequencer still busy");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SHIFT) |-> count_ff != '0)
      else $error("remove walk on empty store");

   a_fail_no_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff != STAT_OK) |-> rsp_word_ff == '0)
      else $error("failed request returned a word");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SHIFT || state_ff == ST_GET_RD)
      |=> (count_ff == $past(count_ff) || count_ff == $past(count_ff) - CW'(1)))
      else $error("fill count jumped during get or remove");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import ias_pkg::*;

   localparam int STORE_DEPTH = 256;

   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] read_word;
      logic [FILL_W-1:0]        fill;
   } outcome_t;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   op_type                   req_op;
   logic [SLOT_W-1:0]        req_slot_index;
   logic signed [WORD_W-1:0] req_word_value;
   logic                     rsp_strobe;
   status_type               rsp_status;
   logic signed [WORD_W-1:0] rsp_read_word;
   logic [FILL_W-1:0]        rsp_fill_count;

   // Shadow copy of the array and its fill count
   logic signed [WORD_W-1:0] shadow_words [STORE_DEPTH];
   int                       shadow_fill = 0;
   outcome_t                 expected_outcomes [$];
   int                       mismatch_count = 0;
   bit                       sender_gaps = 1'b1;

   indexed_array_store #(.DEPTH(STORE_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_slot_index (req_slot_index),
      .req_word_value (req_word_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_read_word  (rsp_read_word),
      .rsp_fill_count (rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // Apply one request to the shadow array and return the result it yields
   function automatic outcome_t apply_store_op(op_type op, logic [SLOT_W-1:0] slot,
                                               logic signed [WORD_W-1:0] word);
      outcome_t res;
      int pos;
      res.status = STAT_OK;
      res.read_word = '0;
      case (op)
         OP_APPEND: begin
            if (shadow_fill >= STORE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_words[shadow_fill] = word;
               shadow_fill++;
            end
         end
         OP_GET: begin
            if (int'(slot) >= shadow_fill) begin
               res.status = STAT_RANGE;
            end else begin
               res.read_word = shadow_words[slot];
            end
         end
         OP_SET: begin
            if (int'(slot) >= STORE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               // zero the gap between the old end and the slot
               for (pos = shadow_fill; pos < int'(slot); pos++) begin
                  shadow_words[pos] = '0;
               end
               if (int'(slot) >= shadow_fill) begin
                  shadow_fill = int'(slot) + 1;
               end
               shadow_words[slot] = word;
            end
         end
         default: begin
            // find the first match, then close the gap
            pos = 0;
            while (pos < shadow_fill && shadow_words[pos] != word) begin
               pos++;
            end
            if (pos >= shadow_fill) begin
               res.status = STAT_MISSING;
            end else begin
               while (pos + 1 < shadow_fill) begin
                  shadow_words[pos] = shadow_words[pos + 1];
                  pos++;
               end
               shadow_fill--;
            end
         end
      endcase
      res.fill = shadow_fill[FILL_W-1:0];
      return res;
   endfunction

   // Drive one request and hold it until the block takes it
   task automatic send_word(op_type op, logic [SLOT_W-1:0] slot,
                            logic signed [WORD_W-1:0] word);
      int gap;
      if (sender_gaps && $urandom_range(99) < 21) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_slot_index <= slot;
      req_word_value <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_outcomes.push_back(apply_store_op(op, slot, word));
   endtask

   // Favor a few small values so that duplicates occur
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0, 1, 2: return $urandom_range(3);
         3: begin
            case ($urandom_range(3))
               0:       return 32'h7fffffff;
               1:       return 32'h80000000;
               2:       return '1;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      outcome_t want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            end
            if (rsp_read_word !== want.read_word) begin
               report_mismatch($sformatf("read_word %h, want %h", rsp_read_word,
                                         want.read_word));
            end
            if (rsp_fill_count !== want.fill) begin
               report_mismatch($sformatf("fill_count %0d, want %0d", rsp_fill_count,
                                         want.fill));
            end
         end
      end
   end

   // Empty-store cases, extreme words, set inside the array and remove
   task automatic test_directed_basics();
      send_word(OP_GET, 8'd0, 32'sd0);
      send_word(OP_REMOVE, 8'd0, 32'sd0);
      send_word(OP_APPEND, 8'd0, 32'h7fffffff);
      send_word(OP_APPEND, 8'hff, 32'h80000000);
      send_word(OP_APPEND, 8'd0, 32'h00000000);
      send_word(OP_APPEND, 8'd0, 32'hffffffff);
      send_word(OP_GET, 8'd0, 32'hffffffff);
      send_word(OP_GET, 8'd1, 32'sd0);
      send_word(OP_GET, 8'd2, 32'sd0);
      send_word(OP_GET, 8'd3, 32'sd0);
      send_word(OP_GET, 8'hff, 32'sd0);
      send_word(OP_SET, 8'd1, 32'h5a5a5a5a);
      send_word(OP_REMOVE, 8'd0, 32'h00000000);
      send_word(OP_REMOVE, 8'd0, 32'h12345678);
   endtask

   // Set past the end with a gap, then exactly at the end
   task automatic test_gap_fill();
      send_word(OP_SET, 8'd10, 32'hdeadbeef);
      send_word(OP_GET, 8'd5, 32'sd0);
      send_word(OP_SET, 8'd11, -32'sd2);
      send_word(OP_GET, 8'd11, 32'sd0);
   endtask

   // Fill to capacity, append when full, remove last and first entries
   task automatic test_full_store();
      send_word(OP_SET, 8'd255, 32'h0badf00d);
      send_word(OP_APPEND, 8'd0, 32'h11111111);
      send_word(OP_GET, 8'd255, 32'sd0);
      send_word(OP_GET, 8'd254, 32'sd0);
      send_word(OP_REMOVE, 8'd0, 32'h0badf00d);
      send_word(OP_APPEND, 8'd0, 32'h22222222);
      send_word(OP_REMOVE, 8'd0, 32'h7fffffff);
      send_word(OP_GET, 8'd0, 32'sd0);
   endtask

   // Random traffic that alternates between growing and draining the array
   task automatic test_random_traffic(int n_items);
      bit growing;
      int k;
      int pick;
      int extra;
      op_type op;
      logic [SLOT_W-1:0] slot;
      logic signed [WORD_W-1:0] word;
      growing = 1'b1;
      for (k = 0; k < n_items; k++) begin
         // keep a long stretch free of sender gaps
         sender_gaps = !(k >= 400 && k < 800);
         if (shadow_fill == 0) begin
            growing = 1'b1;
         end else if (shadow_fill == STORE_DEPTH && $urandom_range(5) == 0) begin
            growing = 1'b0;
         end else if ($urandom_range(149) == 0) begin
            growing = !growing;
         end
         pick = $urandom_range(99);
         if (growing) begin
            op = (pick < 40) ? OP_APPEND : (pick < 60) ? OP_SET :
                 (pick < 80) ? OP_GET : OP_REMOVE;
         end else begin
            op = (pick < 10) ? OP_APPEND : (pick < 20) ? OP_SET :
                 (pick < 40) ? OP_GET : OP_REMOVE;
         end
         word = pick_word();
         slot = SLOT_W'($urandom);
         case (op)
            OP_GET: begin
               if (shadow_fill > 0 && $urandom_range(4) != 0) begin
                  slot = SLOT_W'($urandom_range(shadow_fill - 1));
               end
            end
            OP_SET: begin
               pick = $urandom_range(99);
               extra = $urandom_range(8);
               if (pick < 2) begin
                  slot = 8'd255;
               end else if (pick < 55) begin
                  slot = SLOT_W'($urandom_range(shadow_fill < STORE_DEPTH ?
                                                shadow_fill : STORE_DEPTH - 1));
               end else if (pick < 85) begin
                  slot = (shadow_fill + extra > 255) ? 8'd255 :
                         SLOT_W'(shadow_fill + extra);
               end
            end
            OP_REMOVE: begin
               if (shadow_fill > 0 && $urandom_range(3) != 0) begin
                  word = shadow_words[$urandom_range(shadow_fill - 1)];
               end
            end
            default: begin
            end
         endcase
         send_word(op, slot, word);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_APPEND;
      req_slot_index = '0;
      req_word_value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_gap_fill();
      test_full_store();
      test_random_traffic(1425);
      start <= 1'b0;
      // drain outstanding results, then watch for stray strobes
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS indexed_array_store");
      end else begin
         $display("FAIL indexed_array_store");
      end
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #100_000_000;
      $display("FAIL indexed_array_store");
      $finish;
   end

endmodule

>>> files.f
sv/ias_pkg.sv
sv/ias_ram.sv
sv/indexed_array_store.sv
sim/tb.sv
